/* hw/rtl/planar_video_register_and_memory_port_defines.svh */
// assertion macros included by the back end rtl file
`ifndef PLANAR_VIDEO_REGISTER_AND_MEMORY_PORT_DEFINES_SVH
`define PLANAR_VIDEO_REGISTER_AND_MEMORY_PORT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PVRMP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PVRMP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pvrmp_pkg.sv */
package pvrmp_pkg;

	// plane geometry
	localparam int PLANE_ADDR_BITS_DEF = 14;
	localparam int STORE_ADDR_BITS     = 16;
	localparam int NUM_PLANES          = 4;

	// request queue depth
	localparam int QUEUE_DEPTH = 2;

	// i/o port numbers
	localparam logic [15:0] PORT_INDEX    = 16'h03d4;
	localparam logic [15:0] PORT_DATA     = 16'h03d5;
	localparam logic [15:0] PORT_MODE     = 16'h03d8;
	localparam logic [15:0] PORT_PLANE_WR = 16'h03dd;
	localparam logic [15:0] PORT_PLANE_RD = 16'h03de;
	localparam logic [15:0] PORT_STATUS   = 16'h03da;

	// mode and read constants
	localparam logic [7:0] MODE_PLANAR   = 8'h12;
	localparam logic [7:0] MODE_RESET    = 8'h12;
	localparam logic [7:0] UNMAPPED_READ = 8'hff;
	localparam logic [3:0] ALL_PLANES    = 4'hf;

	// first crtc register with no writable bits
	localparam logic [4:0] CRTC_FIRST_UNUSED = 5'd18;

	typedef enum logic [1:0] {
		OP_PORT_WR = 2'd0,
		OP_PORT_RD = 2'd1,
		OP_MEM_WR  = 2'd2,
		OP_MEM_RD  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PK_INDEX,
		PK_DATA,
		PK_MODE,
		PK_PLANE_WR,
		PK_PLANE_RD,
		PK_STATUS,
		PK_OTHER
	} port_kind_t;

	// classified request as it travels through the queue
	typedef struct packed {
		op_t        op;
		port_kind_t kind;
		logic [7:0] data;
	} req_t;

	// writable bits of each crtc register
	function automatic logic [7:0] crtc_mask(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'd0, 5'd1, 5'd2, 5'd3: m = 8'hff;
			5'd4:                   m = 8'h7f;
			5'd5:                   m = 8'h1f;
			5'd6, 5'd7:             m = 8'h7f;
			5'd8:                   m = 8'hf3;
			5'd9:                   m = 8'h1f;
			5'd10:                  m = 8'h7f;
			5'd11:                  m = 8'h1f;
			5'd12:                  m = 8'h3f;
			5'd13:                  m = 8'hff;
			5'd14:                  m = 8'h3f;
			5'd15, 5'd16, 5'd17:    m = 8'hff;
			default:                m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic planar_on(input logic [7:0] m);
		return (m & MODE_PLANAR) == MODE_PLANAR;
	endfunction

endpackage

/* hw/rtl/planar_video_register_and_memory_port.sv */
// Host-side register and memory port of a CGA-style video adapter with four
// memory planes. A request is taken on a clock edge with start high and busy
// low; func selects port write, port read, memory write or memory read. Port
// and memory reads return one byte on read_data with done high for exactly
// one cycle; writes return nothing. The receiver cannot stall: read_data is
// valid only in the done cycle. A decode front end feeds a two-entry request
// queue, and the execute back end drains one request per cycle, so a request
// can be issued every cycle and busy only rises if the queue fills. Each plane
// memory has a single access port. Plane memory contents are undefined after
// reset until written; registers reset to their defaults.
module planar_video_register_and_memory_port import pvrmp_pkg::*; #(
	parameter int PLANE_ADDR_BITS = PLANE_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data
);

	localparam int ENTRY_BITS = $bits(req_t) + PLANE_ADDR_BITS;

	logic                       push;
	req_t                       front_req;
	logic [PLANE_ADDR_BITS-1:0] front_addr;
	logic                       queue_full;
	logic                       pop;
	logic                       head_valid;
	logic [ENTRY_BITS-1:0]      head_entry;
	req_t                       back_req;
	logic [PLANE_ADDR_BITS-1:0] back_addr;

	assign busy = queue_full;

	// decode and accept
	pvrmp_front #(
		.PLANE_ADDR_BITS(PLANE_ADDR_BITS)
	) u_front (
		.start     (start),
		.busy      (queue_full),
		.func      (func),
		.address   (address),
		.write_data(write_data),
		.push      (push),
		.req       (front_req),
		.mem_addr  (front_addr)
	);

	// request queue between decode and execute
	pvrmp_queue #(
		.WIDTH(ENTRY_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_req, front_addr}),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_entry)
	);

	assign back_req  = req_t'(head_entry[ENTRY_BITS-1:PLANE_ADDR_BITS]);
	assign back_addr = head_entry[PLANE_ADDR_BITS-1:0];

	// execute
	pvrmp_back #(
		.PLANE_ADDR_BITS(PLANE_ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.req       (back_req),
		.mem_addr  (back_addr),
		.pop       (pop),
		.done      (done),
		.read_data (read_data)
	);

endmodule

/* hw/rtl/pvrmp_front.sv */
module pvrmp_front import pvrmp_pkg::*; #(
	parameter int PLANE_ADDR_BITS = PLANE_ADDR_BITS_DEF
) (
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 func,
	input  logic [15:0]                address,
	input  logic [7:0]                 write_data,
	output logic                       push,
	output req_t                       req,
	output logic [PLANE_ADDR_BITS-1:0] mem_addr
);

	assign push = start && !busy;

	// classify the request and decode the port number once
	always_comb begin
		req.op   = op_t'(func);
		req.data = write_data;
		case (address)
			PORT_INDEX:    req.kind = PK_INDEX;
			PORT_DATA:     req.kind = PK_DATA;
			PORT_MODE:     req.kind = PK_MODE;
			PORT_PLANE_WR: req.kind = PK_PLANE_WR;
			PORT_PLANE_RD: req.kind = PK_PLANE_RD;
			PORT_STATUS:   req.kind = PK_STATUS;
			default:       req.kind = PK_OTHER;
		endcase
	end

	// offset inside one plane
	assign mem_addr = address[PLANE_ADDR_BITS-1:0];

endmodule

/* hw/rtl/pvrmp_queue.sv */
module pvrmp_queue import pvrmp_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_pop;

	assign full       = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/pvrmp_back.sv */
module pvrmp_back import pvrmp_pkg::*; #(
	parameter int PLANE_ADDR_BITS = PLANE_ADDR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  req_t                       req,
	input  logic [PLANE_ADDR_BITS-1:0] mem_addr,
	output logic                       pop,
	output logic                       done,
	output logic [7:0]                 read_data
);

	`include "planar_video_register_and_memory_port_defines.svh"

	// planes that stay apart once the store index wraps at 16 bits
	localparam int NUM_BANKS  = (STORE_ADDR_BITS - PLANE_ADDR_BITS >= 2) ? NUM_PLANES :
		(1 << (STORE_ADDR_BITS - PLANE_ADDR_BITS));
	localparam int BANK_BITS  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int BANK_DEPTH = 1 << PLANE_ADDR_BITS;

	logic [4:0]           crtc_index_q;
	logic [7:0]           crtc_file_q [32];
	logic [7:0]           mode_q;
	logic [3:0]           wmask_q;
	logic [1:0]           rsel_q;
	logic                 tog_q;
	logic                 done_q;
	logic                 mread_q;
	logic [7:0]           pdata_q;
	logic [BANK_BITS-1:0] bank_q;
	logic [7:0]           bank_rd_q [NUM_BANKS];

	logic                 port_wr;
	logic                 port_rd;
	logic                 mem_wr;
	logic                 mem_rd;
	logic                 read_go;
	logic                 status_rd;
	logic                 planar_entry;
	logic                 planar;
	logic [7:0]           port_rdata;
	logic [NUM_BANKS-1:0] bank_we;
	logic [BANK_BITS-1:0] rd_bank;

	// the back end never stalls, so the head is taken whenever present
	assign pop          = head_valid;
	assign port_wr      = head_valid && (req.op == OP_PORT_WR);
	assign port_rd      = head_valid && (req.op == OP_PORT_RD);
	assign mem_wr       = head_valid && (req.op == OP_MEM_WR);
	assign mem_rd       = head_valid && (req.op == OP_MEM_RD);
	assign read_go      = port_rd || mem_rd;
	assign status_rd    = port_rd && (req.kind == PK_STATUS);
	assign planar       = planar_on(mode_q);
	assign planar_entry = port_wr && (req.kind == PK_MODE) && planar_on(req.data) && !planar;

	// register file updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crtc_index_q <= '0;
			for (int i = 0; i < 32; i++) begin
				crtc_file_q[i] <= '0;
			end
			mode_q  <= MODE_RESET;
			wmask_q <= '0;
			rsel_q  <= '0;
			tog_q   <= 1'b0;
		end else begin
			if (port_wr) begin
				case (req.kind)
					PK_INDEX: begin
						crtc_index_q <= req.data[4:0];
					end
					PK_DATA: begin
						crtc_file_q[crtc_index_q] <= req.data & crtc_mask(crtc_index_q);
					end
					PK_MODE: begin
						if (planar_entry) begin
							wmask_q <= ALL_PLANES;
							rsel_q  <= '0;
						end
						mode_q <= req.data;
					end
					PK_PLANE_WR: begin
						wmask_q <= req.data[3:0];
					end
					PK_PLANE_RD: begin
						rsel_q <= req.data[1:0];
					end
					default: begin
					end
				endcase
			end
			if (status_rd) begin
				tog_q <= ~tog_q;
			end
		end
	end

	// port read value
	always_comb begin
		case (req.kind)
			PK_INDEX:  port_rdata = {3'b000, crtc_index_q};
			PK_DATA:   port_rdata = crtc_file_q[crtc_index_q];
			PK_STATUS: port_rdata = {7'b0000000, tog_q};
			default:   port_rdata = UNMAPPED_READ;
		endcase
	end

	// plane write enables folded onto the physical banks
	always_comb begin
		bank_we = '0;
		if (mem_wr) begin
			if (planar) begin
				for (int p = 0; p < NUM_PLANES; p++) begin
					if (wmask_q[p]) begin
						bank_we[p % NUM_BANKS] = 1'b1;
					end
				end
			end else begin
				bank_we[0] = 1'b1;
			end
		end
	end

	assign rd_bank = planar ? BANK_BITS'({1'b0, rsel_q} % 3'(NUM_BANKS)) : '0;

	// plane memories, one write or read port each
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [7:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (bank_we[b]) begin
				mem[mem_addr] <= req.data;
			end
			if (mem_rd) begin
				bank_rd_q[b] <= mem[mem_addr];
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= read_go;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (read_go) begin
			mread_q <= mem_rd;
			pdata_q <= port_rdata;
			bank_q  <= rd_bank;
		end
	end

	assign done      = done_q;
	assign read_data = mread_q ? bank_rd_q[bank_q] : pdata_q;

	// checks
	`PVRMP_ASSERT_NXT(a_read_gives_result, read_go, done_q, "read request produced no result")
	`PVRMP_ASSERT_NXT(a_no_stray_result, !read_go, !done_q, "result without a read request")
	`PVRMP_ASSERT_NXT(a_planar_entry_opens_planes, planar_entry, (wmask_q == ALL_PLANES) && (rsel_q == 2'd0), "planar entry did not reset plane controls")
	`PVRMP_ASSERT_NXT(a_status_toggles, status_rd, tog_q != $past(tog_q), "status read did not flip toggle")
	`PVRMP_ASSERT_IMP(a_unused_crtc_zero, crtc_index_q >= CRTC_FIRST_UNUSED, crtc_file_q[crtc_index_q] == 8'h00, "unused crtc register holds data")

endmodule

/* test/planar_video_register_and_memory_port_tb.sv */
`timescale 1ns / 1ps

module planar_video_register_and_memory_port_tb;
	import pvrmp_pkg::*;

	localparam int PLANE_BITS = PLANE_ADDR_BITS_DEF;
	localparam logic [15:0] OFFSET_MASK = 16'((32'd1 << PLANE_BITS) - 1);
	localparam logic [15:0] PORT_COLOR  = 16'h03d9;
	localparam logic [15:0] PORT_BORDER = 16'h03df;
	localparam int RANDOM_PER_PHASE = 488;
	localparam int NUM_PHASES = 4;
	localparam int IDLE_PCT [NUM_PHASES] = '{0, 47, 12, 0};

	// writable bits of each crtc register, 18 and up have none
	localparam logic [7:0] CRTC_WRITABLE [32] = '{
		8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
		8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff,
		8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        typed;
		logic [7:0]  want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 27;

	// reset values, extremes, status toggle, unmapped ports, crtc masks,
	// colour and border ports, mode switch and plane routing
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_PORT_RD, PORT_INDEX,    8'h00, 1'b1, 8'h00},
		'{OP_PORT_RD, PORT_DATA,     8'h00, 1'b1, 8'h00},
		'{OP_PORT_RD, PORT_STATUS,   8'hff, 1'b1, 8'h00},
		'{OP_PORT_RD, PORT_STATUS,   8'h00, 1'b1, 8'h01},
		'{OP_PORT_RD, 16'hffff,      8'h00, 1'b1, 8'hff},
		'{OP_PORT_RD, 16'h0000,      8'hff, 1'b1, 8'hff},
		'{OP_PORT_WR, PORT_INDEX,    8'he8, 1'b0, 8'h00},
		'{OP_PORT_WR, PORT_DATA,     8'hff, 1'b0, 8'h00},
		'{OP_PORT_RD, PORT_DATA,     8'h00, 1'b1, 8'hf3},
		'{OP_PORT_WR, PORT_INDEX,    8'hff, 1'b0, 8'h00},
		'{OP_PORT_RD, PORT_INDEX,    8'h00, 1'b1, 8'h1f},
		'{OP_PORT_WR, PORT_DATA,     8'hff, 1'b0, 8'h00},
		'{OP_PORT_RD, PORT_DATA,     8'h00, 1'b1, 8'h00},
		'{OP_PORT_WR, PORT_COLOR,    8'hff, 1'b0, 8'h00},
		'{OP_PORT_WR, PORT_BORDER,   8'hff, 1'b0, 8'h00},
		'{OP_PORT_WR, 16'hffff,      8'h00, 1'b0, 8'h00},
		'{OP_PORT_WR, PORT_MODE,     8'h00, 1'b0, 8'h00},
		'{OP_MEM_WR,  16'hffff,      8'h5a, 1'b0, 8'h00},
		'{OP_MEM_RD,  16'h3fff,      8'h00, 1'b1, 8'h5a},
		'{OP_PORT_WR, PORT_MODE,     8'hff, 1'b0, 8'h00},
		'{OP_MEM_WR,  16'h0000,      8'hc3, 1'b0, 8'h00},
		'{OP_PORT_WR, PORT_PLANE_WR, 8'h04, 1'b0, 8'h00},
		'{OP_MEM_WR,  16'hc000,      8'hff, 1'b0, 8'h00},
		'{OP_PORT_WR, PORT_PLANE_RD, 8'hfe, 1'b0, 8'h00},
		'{OP_MEM_RD,  16'h4000,      8'h00, 1'b1, 8'hff},
		'{OP_PORT_WR, PORT_PLANE_RD, 8'h03, 1'b0, 8'h00},
		'{OP_MEM_RD,  16'h8000,      8'h00, 1'b1, 8'hc3}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        done;
	logic [7:0]  read_data;

	// predicted adapter state
	logic [4:0]  crtc_index;
	logic [7:0]  crtc_file [32];
	logic [7:0]  mode_reg;
	logic [3:0]  plane_write_mask;
	logic [1:0]  plane_read_sel;
	logic        status_toggle;
	logic [7:0]  vram_copy [0:65535];
	logic [15:0] written_cells [$];

	logic [7:0]  pending_reads [$];
	int          mismatch_count;

	planar_video_register_and_memory_port #(
		.PLANE_ADDR_BITS(PLANE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.address(address),
		.write_data(write_data),
		.done(done),
		.read_data(read_data)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic planar_mode(input logic [7:0] m);
		return (m & MODE_PLANAR) == MODE_PLANAR;
	endfunction

	function automatic logic [15:0] cell_index(input logic [15:0] a, input logic [1:0] plane);
		return 16'((32'(plane) << PLANE_BITS) | 32'(a & OFFSET_MASK));
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at %0t ns: %s, got %02h, want %02h", $time, what, got, want);
		mismatch_count++;
	endtask

	// apply one request to the predicted state, return the byte a read gives
	task automatic apply_request(input op_t op, input logic [15:0] a, input logic [7:0] d,
			output bit has_read, output logic [7:0] rd);
		logic [1:0]  plane;
		logic [15:0] vram_idx;
		has_read = 1'b0;
		rd = 8'h00;
		case (op)
			OP_PORT_WR: begin
				if (a == PORT_INDEX) begin
					crtc_index = d[4:0];
				end else if (a == PORT_DATA) begin
					crtc_file[crtc_index] = d & CRTC_WRITABLE[crtc_index];
				end else if (a == PORT_MODE) begin
					// entering planar mode opens all planes for writing
					if (planar_mode(d) && !planar_mode(mode_reg)) begin
						plane_write_mask = ALL_PLANES;
						plane_read_sel = 2'd0;
					end
					mode_reg = d;
				end else if (a == PORT_PLANE_WR) begin
					plane_write_mask = d[3:0];
				end else if (a == PORT_PLANE_RD) begin
					plane_read_sel = d[1:0];
				end
			end
			OP_PORT_RD: begin
				has_read = 1'b1;
				if (a == PORT_INDEX) begin
					rd = {3'b000, crtc_index};
				end else if (a == PORT_DATA) begin
					rd = crtc_file[crtc_index];
				end else if (a == PORT_STATUS) begin
					rd = {7'b0000000, status_toggle};
					status_toggle = ~status_toggle;
				end else begin
					rd = UNMAPPED_READ;
				end
			end
			OP_MEM_WR: begin
				for (int p = 0; p < NUM_PLANES; p++) begin
					if (planar_mode(mode_reg) ? plane_write_mask[p] : (p == 0)) begin
						vram_idx = cell_index(a, 2'(p));
						vram_copy[vram_idx] = d;
						written_cells.push_back(vram_idx);
					end
				end
			end
			default: begin
				has_read = 1'b1;
				plane = planar_mode(mode_reg) ? plane_read_sel : 2'd0;
				rd = vram_copy[cell_index(a, plane)];
			end
		endcase
	endtask

	// drive one request and wait until it is taken
	task automatic send_request(input op_t op, input logic [15:0] a, input logic [7:0] d,
			input logic typed, input logic [7:0] typed_val);
		bit         has_read;
		logic [7:0] rd;
		start <= 1'b1;
		func <= op;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (busy !== 1'b0);
		apply_request(op, a, d, has_read, rd);
		if (has_read)
			pending_reads.push_back(typed ? typed_val : rd);
	endtask

	// sender gap, with junk on the request fields
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		func <= 2'($urandom);
		address <= 16'($urandom);
		write_data <= 8'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every read has come back
	task automatic drain_reads();
		start <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// random request, mostly aimed at the mapped ports and at written memory
	task automatic random_request(output op_t op, output logic [15:0] a, output logic [7:0] d);
		int          pick;
		bit          ok;
		logic [1:0]  plane;
		logic [15:0] found;
		d = 8'($urandom);
		a = 16'($urandom);
		pick = $urandom_range(0, 99);
		ok = 1'b0;
		found = 16'h0000;
		if (pick < 35) begin
			op = OP_PORT_WR;
			case ($urandom_range(0, 7))
				0: a = PORT_INDEX;
				1: a = PORT_DATA;
				2: begin
					a = PORT_MODE;
					case ($urandom_range(0, 2))
						0: d = d | MODE_PLANAR;
						1: d = d & ~MODE_PLANAR;
						default: ;
					endcase
				end
				3: a = PORT_PLANE_WR;
				4: a = PORT_PLANE_RD;
				5: a = PORT_COLOR;
				6: a = PORT_BORDER;
				default: ;
			endcase
		end else if (pick < 55) begin
			op = OP_PORT_RD;
			case ($urandom_range(0, 3))
				0: a = PORT_INDEX;
				1: a = PORT_DATA;
				2: a = PORT_STATUS;
				default: ;
			endcase
		end else if (pick < 80 || written_cells.size() == 0) begin
			op = OP_MEM_WR;
			// crowd half the writes onto a few offsets at both ends
			if ($urandom_range(0, 1))
				a = (a & ~OFFSET_MASK) | ($urandom_range(0, 1) ? 16'($urandom_range(0, 15))
					: OFFSET_MASK - 16'($urandom_range(0, 15)));
		end else begin
			op = OP_MEM_RD;
			// only cells already written on the plane that reads come from
			plane = planar_mode(mode_reg) ? plane_read_sel : 2'd0;
			for (int t = 0; t < 24 && !ok; t++) begin
				found = (t == 0) ? written_cells[written_cells.size() - 1]
					: written_cells[$urandom_range(0, written_cells.size() - 1)];
				ok = (found >> PLANE_BITS) == 16'(plane);
			end
			if (ok)
				a = (a & ~OFFSET_MASK) | (found & OFFSET_MASK);
			else
				op = OP_MEM_WR;
		end
	endtask

	// compare each returned byte with the oldest outstanding read
	always @(posedge clk) begin : check_reads
		logic [7:0] want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("read data with no read outstanding", read_data, 8'h00);
			end else begin
				want = pending_reads.pop_front();
				if (read_data !== want)
					report_mismatch("read_data", read_data, want);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		op_t         op;
		logic [15:0] a;
		logic [7:0]  d;
		mismatch_count = 0;
		crtc_index = 5'd0;
		foreach (crtc_file[i])
			crtc_file[i] = 8'h00;
		mode_reg = MODE_RESET;
		plane_write_mask = 4'h0;
		plane_read_sel = 2'd0;
		status_toggle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = OP_PORT_WR;
		address = 16'h0000;
		write_data = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_request(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data,
				DIRECTED[i].typed, DIRECTED[i].want);

		// random phases with different sender gaps
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < IDLE_PCT[ph])
					hold_off($urandom_range(1, 3));
				random_request(op, a, d);
				send_request(op, a, d, 1'b0, 8'h00);
			end
			if (ph == 1)
				drain_reads();
		end

		drain_reads();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pvrmp_pkg.sv
hw/rtl/pvrmp_front.sv
hw/rtl/pvrmp_queue.sv
hw/rtl/pvrmp_back.sv
hw/rtl/planar_video_register_and_memory_port.sv
test/planar_video_register_and_memory_port_tb.sv
